// File: design/glos_pkg.sv
`timescale 1ns / 1ps

package glos_pkg;

  localparam int VIEW_WIDTH  = 11;
  localparam int VIEW_HEIGHT = 11;
  localparam int CX          = VIEW_WIDTH / 2;
  localparam int CY          = VIEW_HEIGHT / 2;
  localparam int ROW_W       = 4;
  localparam int BITS_W      = 11;

  localparam logic [ROW_W-1:0] CENTER_ROW = ROW_W'(CY);
  localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(VIEW_HEIGHT - 1);

  typedef struct packed {
    logic [ROW_W-1:0]  row_index;
    logic [BITS_W-1:0] row_opacity;
    logic              compute;
  } load_beat_t;

  typedef struct packed {
    logic [ROW_W-1:0]  out_row;
    logic [BITS_W-1:0] visible_bits;
    logic              last_row;
  } row_beat_t;

  typedef struct packed {
    logic             load;
    logic             calc;
    logic [ROW_W-1:0] calc_row;
    logic             center;
    logic             from_center;
    logic             emit;
    logic [ROW_W-1:0] emit_row;
    logic             emit_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic all_visible;
  } status_t;

endpackage

// File: design/glos_ctrl.sv
`timescale 1ns / 1ps

module glos_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load_valid,
  input  logic                 load_compute,
  output logic                 load_stall,
  input  glos_pkg::status_t    status,
  output glos_pkg::cmd_t       cmd
);

  typedef enum logic [1:0] {
    IDLE,
    CALC,
    EMIT
  } state_t;

  state_t                      state;
  logic [glos_pkg::ROW_W-1:0]  calc_row;
  logic [glos_pkg::ROW_W-1:0]  emit_row;
  logic                        down;
  logic                        from_center;
  logic                        accept;
  logic                        emit_last;

  assign accept    = load_valid && !load_stall;
  assign emit_last = (emit_row == glos_pkg::LAST_ROW);

  always_comb begin
    cmd             = '0;
    cmd.load        = accept;
    cmd.calc        = (state == CALC);
    cmd.calc_row    = calc_row;
    cmd.center      = (calc_row == glos_pkg::CENTER_ROW) && !down;
    cmd.from_center = from_center;
    cmd.emit        = (state == EMIT) && status.out_free;
    cmd.emit_row    = emit_row;
    cmd.emit_last   = emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      load_stall  <= 1'b0;
      calc_row    <= '0;
      emit_row    <= '0;
      down        <= 1'b0;
      from_center <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (accept && load_compute) begin
            load_stall  <= 1'b1;
            calc_row    <= glos_pkg::CENTER_ROW;
            emit_row    <= '0;
            down        <= 1'b0;
            from_center <= 1'b0;
            state       <= status.all_visible ? EMIT : CALC;
          end
        end
        CALC: begin
          from_center <= 1'b0;
          if (!down) begin
            if (calc_row == '0) begin
              calc_row    <= glos_pkg::CENTER_ROW + 1'b1;
              down        <= 1'b1;
              from_center <= 1'b1;
            end else begin
              calc_row <= calc_row - 1'b1;
            end
          end else if (calc_row == glos_pkg::LAST_ROW) begin
            state <= EMIT;
          end else begin
            calc_row <= calc_row + 1'b1;
          end
        end
        EMIT: begin
          if (status.out_free) begin
            if (emit_last) begin
              state      <= IDLE;
              load_stall <= 1'b0;
            end else begin
              emit_row <= emit_row + 1'b1;
            end
          end
        end
        default: begin
          state      <= IDLE;
          load_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: design/glos_dp.sv
`timescale 1ns / 1ps

module glos_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic                  cfg_wdata,
  input  glos_pkg::load_beat_t  load_beat,
  input  glos_pkg::cmd_t        cmd,
  output glos_pkg::status_t     status,
  output logic                  row_valid,
  input  logic                  row_stall,
  output glos_pkg::row_beat_t   row_beat
);

  localparam int W = glos_pkg::VIEW_WIDTH;
  localparam int H = glos_pkg::VIEW_HEIGHT;

  logic [W-1:0] opacity [H];
  logic [W-1:0] vis     [H];
  logic [W-1:0] prev_pass;
  logic [W-1:0] center_pass;
  logic [W-1:0] prev_sel;
  logic [W-1:0] opq_cur;
  logic [W-1:0] vis_row;
  logic [W-1:0] pass_cur;
  logic         all_visible;

  assign status.out_free    = !row_valid || !row_stall;
  assign status.all_visible = all_visible;

  assign opq_cur  = opacity[cmd.calc_row];
  assign prev_sel = cmd.center ? '0 : (cmd.from_center ? center_pass : prev_pass);
  assign pass_cur = vis_row & ~opq_cur;

  // spread from the inward row, then outward along the row
  always_comb begin
    vis_row                = '0;
    vis_row[glos_pkg::CX]  = cmd.center ? 1'b1 : prev_sel[glos_pkg::CX];
    for (int i = glos_pkg::CX - 1; i >= 0; i--) begin
      vis_row[i] = prev_sel[i] | (vis_row[i+1] & ~opq_cur[i+1]) | prev_sel[i+1];
    end
    for (int i = glos_pkg::CX + 1; i < W; i++) begin
      vis_row[i] = prev_sel[i] | (vis_row[i-1] & ~opq_cur[i-1]) | prev_sel[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      all_visible <= 1'b0;
    end else if (cfg_wen) begin
      all_visible <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (load_beat.row_index < glos_pkg::ROW_W'(H))) begin
      opacity[load_beat.row_index] <= load_beat.row_opacity[W-1:0];
    end
    if (cmd.calc) begin
      vis[cmd.calc_row] <= vis_row;
      prev_pass         <= pass_cur;
      if (cmd.center) begin
        center_pass <= pass_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
    end else if (cmd.emit) begin
      row_valid <= 1'b1;
    end else if (!row_stall) begin
      row_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      row_beat.out_row      <= cmd.emit_row;
      row_beat.visible_bits <= all_visible ? {W{1'b1}} : vis[cmd.emit_row];
      row_beat.last_row     <= cmd.emit_last;
    end
  end

endmodule

// File: design/grid_line_of_sight_core.sv
// a compute beat's first row beat is presented after row-by-row spreading, one step
// per grid row, and then the output register; with all_visible set the spreading is
// skipped and the EMIT state goes straight to the output register
// load-only beats are accepted back to back; a compute beat holds off the next load
// through acceptance, calc and emit (emit only, with all_visible), plus output stalls
// reset: synchronous active-high rst clears control and all_visible; opacity rows undefined
`timescale 1ns / 1ps

module grid_line_of_sight_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic                  cfg_wdata,
  input  logic                  load_valid,
  output logic                  load_stall,
  input  glos_pkg::load_beat_t  load_beat,
  output logic                  row_valid,
  input  logic                  row_stall,
  output glos_pkg::row_beat_t   row_beat
);

  glos_pkg::cmd_t    cmd;
  glos_pkg::status_t status;

  glos_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (load_valid),
    .load_compute (load_beat.compute),
    .load_stall   (load_stall),
    .status       (status),
    .cmd          (cmd)
  );

  glos_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .load_beat (load_beat),
    .cmd       (cmd),
    .status    (status),
    .row_valid (row_valid),
    .row_stall (row_stall),
    .row_beat  (row_beat)
  );

  a_compute_blocks: assert property (@(posedge clk) disable iff (rst)
    load_valid && !load_stall && load_beat.compute |=> load_stall)
    else $error("compute beat did not block further loads");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    row_valid |-> (row_beat.last_row == (row_beat.out_row == glos_pkg::LAST_ROW)))
    else $error("last_row flag does not match row index");

  a_mid_run_blocks: assert property (@(posedge clk) disable iff (rst)
    row_valid && !row_stall && !row_beat.last_row |-> load_stall)
    else $error("load accepted in the middle of a result run");

endmodule

// File: test/tb_grid_line_of_sight_core.sv
`timescale 1ns / 1ps

module tb_grid_line_of_sight_core;
  import glos_pkg::*;

  typedef enum logic {STEP_LOAD, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t              kind;
    logic                    cfg_val;
    logic [ROW_W-1:0]        row;
    logic [BITS_W-1:0]       opac;
    logic                    go;
    logic                    typed;
    logic [BITS_W-1:0]       exp_mid;
    logic [BITS_W-1:0]       exp_rest;
  } plan_step_t;

  localparam int PLAN_LEN = 25;
  localparam int HOLD_CYCLES = 300;

  logic       clk;
  logic       rst;
  logic       cfg_wen;
  logic       cfg_wdata;
  logic       load_valid;
  logic       load_stall;
  load_beat_t load_beat;
  logic       row_valid;
  logic       row_stall;
  row_beat_t  row_beat;

  logic [VIEW_WIDTH-1:0] opacity_rows [VIEW_HEIGHT];
  logic [VIEW_WIDTH-1:0] sight_rows [VIEW_HEIGHT];
  logic                  all_vis_cfg;
  row_beat_t             pending_rows [$];

  int  mismatches;
  int  burst_left;
  bit  steady_send;
  bit  hold_req;
  int  stall_mode;
  int  stall_left;

  plan_step_t plan [PLAN_LEN] = '{
    '{STEP_CFG,  1'b0, 4'd0,  11'h000, 1'b0, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd0,  11'h000, 1'b0, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd1,  11'h000, 1'b0, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd2,  11'h000, 1'b0, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd3,  11'h000, 1'b0, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd4,  11'h000, 1'b0, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd5,  11'h000, 1'b0, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd6,  11'h000, 1'b0, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd7,  11'h000, 1'b0, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd8,  11'h000, 1'b0, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd9,  11'h000, 1'b0, 1'b0, 11'h000, 11'h000},
    // open map: everything in sight
    '{STEP_LOAD, 1'b0, 4'd10, 11'h000, 1'b1, 1'b1, 11'h7ff, 11'h7ff},
    // opaque centre row: only the centre itself
    '{STEP_LOAD, 1'b0, 4'd5,  11'h7ff, 1'b1, 1'b1, 11'h020, 11'h000},
    '{STEP_CFG,  1'b1, 4'd0,  11'h000, 1'b0, 1'b0, 11'h000, 11'h000},
    // row out of range is dropped, rows are still emitted
    '{STEP_LOAD, 1'b0, 4'd15, 11'h7ff, 1'b1, 1'b1, 11'h7ff, 11'h7ff},
    '{STEP_LOAD, 1'b0, 4'd11, 11'h2aa, 1'b0, 1'b0, 11'h000, 11'h000},
    '{STEP_CFG,  1'b0, 4'd0,  11'h000, 1'b0, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd5,  11'h000, 1'b0, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd0,  11'h7ff, 1'b0, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd10, 11'h7ff, 1'b0, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd3,  11'h555, 1'b1, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd7,  11'h2aa, 1'b0, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd4,  11'h401, 1'b1, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd12, 11'h001, 1'b1, 1'b0, 11'h000, 11'h000},
    '{STEP_LOAD, 1'b0, 4'd6,  11'h3df, 1'b1, 1'b0, 11'h000, 11'h000}
  };

  grid_line_of_sight_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .load_valid (load_valid),
    .load_stall (load_stall),
    .load_beat  (load_beat),
    .row_valid  (row_valid),
    .row_stall  (row_stall),
    .row_beat   (row_beat)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic bit clear_cell(int x, int y);
    if (x < 0 || x >= VIEW_WIDTH || y < 0 || y >= VIEW_HEIGHT) begin
      return 1'b0;
    end
    return sight_rows[y][x] && !opacity_rows[y][x];
  endfunction

  function automatic void sweep_row(int y, int dy);
    for (int x = CX - 1; x >= 0; x--) begin
      if (clear_cell(x, y + dy) || clear_cell(x + 1, y) || clear_cell(x + 1, y + dy)) begin
        sight_rows[y][x] = 1'b1;
      end
    end
    for (int x = CX + 1; x < VIEW_WIDTH; x++) begin
      if (clear_cell(x, y + dy) || clear_cell(x - 1, y) || clear_cell(x - 1, y + dy)) begin
        sight_rows[y][x] = 1'b1;
      end
    end
  endfunction

  function automatic void spread_sight();
    for (int y = 0; y < VIEW_HEIGHT; y++) begin
      sight_rows[y] = all_vis_cfg ? '1 : '0;
    end
    if (!all_vis_cfg) begin
      sight_rows[CY][CX] = 1'b1;
      for (int x = CX - 1; x >= 0; x--) begin
        if (clear_cell(x + 1, CY)) sight_rows[CY][x] = 1'b1;
      end
      for (int x = CX + 1; x < VIEW_WIDTH; x++) begin
        if (clear_cell(x - 1, CY)) sight_rows[CY][x] = 1'b1;
      end
      for (int y = CY - 1; y >= 0; y--) begin
        if (clear_cell(CX, y + 1)) sight_rows[y][CX] = 1'b1;
      end
      for (int y = CY + 1; y < VIEW_HEIGHT; y++) begin
        if (clear_cell(CX, y - 1)) sight_rows[y][CX] = 1'b1;
      end
      for (int y = CY - 1; y >= 0; y--) sweep_row(y, 1);
      for (int y = CY + 1; y < VIEW_HEIGHT; y++) sweep_row(y, -1);
    end
  endfunction

  function automatic load_beat_t rand_beat(bit force_go);
    load_beat_t b;
    logic [BITS_W-1:0] bits;
    if ($urandom_range(0, 9) == 0) begin
      b.row_index = ROW_W'($urandom_range(VIEW_HEIGHT, 15));
    end else begin
      b.row_index = ROW_W'($urandom_range(0, VIEW_HEIGHT - 1));
    end
    case ($urandom_range(0, 5))
      0: bits = '0;
      1: bits = '1;
      2, 3: bits = BITS_W'($urandom & $urandom & $urandom);
      4: bits = BITS_W'($urandom & $urandom);
      default: bits = BITS_W'($urandom);
    endcase
    b.row_opacity = bits;
    b.compute = force_go || ($urandom_range(0, 3) == 0);
    return b;
  endfunction

  // called right after a falling edge, returns right after one
  task automatic push_load(input load_beat_t b, input bit typed,
                           input logic [BITS_W-1:0] exp_mid, input logic [BITS_W-1:0] exp_rest);
    row_beat_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if (!steady_send) begin
        load_valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    load_valid = 1'b1;
    load_beat = b;
    do @(posedge clk); while (load_stall);
    burst_left--;
    if (b.row_index < VIEW_HEIGHT) opacity_rows[b.row_index] = b.row_opacity;
    if (b.compute) begin
      spread_sight();
      for (int y = 0; y < VIEW_HEIGHT; y++) begin
        r.out_row = ROW_W'(y);
        if (typed) begin
          r.visible_bits = (y == CY) ? exp_mid : exp_rest;
        end else begin
          r.visible_bits = sight_rows[y];
        end
        r.last_row = (y == VIEW_HEIGHT - 1);
        pending_rows.push_back(r);
      end
    end
    @(negedge clk);
  endtask

  task automatic set_view_mode(input logic v);
    load_valid = 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_wen = 1'b1;
    cfg_wdata = v;
    all_vis_cfg = v;
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  task automatic note_mismatch(input string what, input logic [15:0] want, input logic [15:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %s: expected %h got %h", what, want, got);
    end
  endtask

  always @(posedge clk) begin
    row_beat_t want;
    if (!rst && row_valid && !row_stall) begin
      if (pending_rows.size() == 0) begin
        note_mismatch("unexpected row beat", 16'h0, 16'(row_beat));
      end else begin
        want = pending_rows.pop_front();
        if (row_beat.out_row !== want.out_row) begin
          note_mismatch("out_row", 16'(want.out_row), 16'(row_beat.out_row));
        end
        if (row_beat.visible_bits !== want.visible_bits) begin
          note_mismatch("visible_bits", 16'(want.visible_bits), 16'(row_beat.visible_bits));
        end
        if (row_beat.last_row !== want.last_row) begin
          note_mismatch("last_row", 16'(want.last_row), 16'(row_beat.last_row));
        end
      end
    end
  end

  // receiver back-pressure
  initial begin
    row_stall = 1'b0;
    stall_mode = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        row_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        row_stall = 1'b0;
      end else begin
        if (stall_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          stall_left = $urandom_range(20, 80);
        end
        stall_left--;
        case (stall_mode)
          0: row_stall = 1'b0;
          1: row_stall = ($urandom_range(0, 3) == 0);
          2: row_stall = ($urandom_range(0, 9) < 7);
          default: row_stall = (stall_left[1:0] != 2'd0);
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    load_beat_t b;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = 1'b0;
    load_valid = 1'b0;
    load_beat = '0;
    all_vis_cfg = 1'b0;
    mismatches = 0;
    burst_left = 0;
    steady_send = 1'b0;
    hold_req = 1'b0;
    for (int y = 0; y < VIEW_HEIGHT; y++) begin
      opacity_rows[y] = '0;
      sight_rows[y] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        set_view_mode(plan[i].cfg_val);
      end else begin
        b.row_index = plan[i].row;
        b.row_opacity = plan[i].opac;
        b.compute = plan[i].go;
        push_load(b, plan[i].typed, plan[i].exp_mid, plan[i].exp_rest);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 1 || ph == 4) begin
        set_view_mode(1'b1);
      end else if (ph == 5) begin
        set_view_mode(1'($urandom_range(0, 1)));
      end else begin
        set_view_mode(1'b0);
      end
      steady_send = (ph % 3 == 1);
      if (ph == 2) begin
        // long receiver hold while passes keep coming
        hold_req = 1'b1;
        repeat (8) push_load(rand_beat(1'b1), 1'b0, '0, '0);
      end
      repeat (20) push_load(rand_beat(1'b0), 1'b0, '0, '0);
    end

    load_valid = 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
